// ===== hw/rtl/dcr_pkg.sv =====
// Shared types, codes and constants for the DMA channel register block.
package dcr_pkg;

    localparam int DEF_NUM_CHANNELS = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    localparam int CHAN_W  = 2;
    localparam int COUNT_W = 17;

    localparam logic [7:0] PORT_ADDR1   = 8'h02;
    localparam logic [7:0] PORT_COUNT1  = 8'h03;
    localparam logic [7:0] PORT_MASK    = 8'h0A;
    localparam logic [7:0] PORT_MODE    = 8'h0B;
    localparam logic [7:0] PORT_CLR_FF  = 8'h0C;
    localparam logic [7:0] PORT_PAGE1   = 8'h83;

    localparam logic [COUNT_W-1:0] COUNT_FULL = 17'h10000;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_FETCH = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WR_ADDR,
        OP_WR_COUNT,
        OP_WR_MASK,
        OP_WR_MODE,
        OP_CLR_FF,
        OP_WR_PAGE,
        OP_RD_COUNT,
        OP_FETCH
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [7:0]        data;
        logic [CHAN_W-1:0] chan;
    } qentry_t;

endpackage

// ===== hw/rtl/dcr_front.sv =====
// Front end: accept transactions and decode them into queue entries.
module dcr_front #(
    parameter int NUM_CHANNELS = dcr_pkg::DEF_NUM_CHANNELS
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dcr_pkg::S_TDATA_W-1:0] s_tdata,  // port[7:0], write_data[15:8], dma_channel[17:16]
    input  logic [dcr_pkg::S_TUSER_W-1:0] s_tuser,  // func[1:0]
    input  logic                          q_full,
    output logic                          q_push,
    output dcr_pkg::qentry_t              q_entry
);
    import dcr_pkg::*;

    func_t             fn;
    logic [7:0]        port;
    logic [7:0]        data;
    logic [CHAN_W-1:0] dch;
    logic [CHAN_W-1:0] mch;
    logic              dch_ok;
    logic              mch_ok;

    assign fn     = func_t'(s_tuser);
    assign port   = s_tdata[7:0];
    assign data   = s_tdata[15:8];
    assign dch    = s_tdata[17:16];
    assign mch    = data[CHAN_W-1:0];
    assign dch_ok = 32'(dch) < NUM_CHANNELS;
    assign mch_ok = 32'(mch) < NUM_CHANNELS;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_entry.op   = OP_NOP;
        q_entry.data = data;
        q_entry.chan = mch;
        unique case (fn)
            FUNC_WRITE:
            begin
                unique case (port)
                    PORT_ADDR1:  q_entry.op = OP_WR_ADDR;
                    PORT_COUNT1: q_entry.op = OP_WR_COUNT;
                    PORT_MASK:   q_entry.op = mch_ok ? OP_WR_MASK : OP_NOP;
                    PORT_MODE:   q_entry.op = mch_ok ? OP_WR_MODE : OP_NOP;
                    PORT_CLR_FF: q_entry.op = OP_CLR_FF;
                    PORT_PAGE1:  q_entry.op = OP_WR_PAGE;
                    default:     q_entry.op = OP_NOP;
                endcase
            end
            FUNC_READ:
            begin
                q_entry.op = (port == PORT_COUNT1) ? OP_RD_COUNT : OP_NOP;
            end
            FUNC_FETCH:
            begin
                q_entry.op   = dch_ok ? OP_FETCH : OP_NOP;
                q_entry.chan = dch;
            end
            FUNC_NONE:
            begin
                q_entry.op = OP_NOP;
            end
            default:
            begin
                q_entry.op = OP_NOP;
            end
        endcase
    end

endmodule

// ===== hw/rtl/dcr_queue.sv =====
// Short FIFO between the decode front end and the execute back end.
module dcr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dcr_pkg::qentry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output dcr_pkg::qentry_t pop_entry
);
    import dcr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    qentry_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign valid     = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/dcr_back.sv =====
// Back end: channel registers, command execution and the output register.
module dcr_back #(
    parameter int NUM_CHANNELS = dcr_pkg::DEF_NUM_CHANNELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  dcr_pkg::qentry_t              q_entry,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dcr_pkg::M_TDATA_W-1:0] m_tdata,  // read_data[7:0], mem_addr[31:8]
    output logic [dcr_pkg::M_TUSER_W-1:0] m_tuser   // fetch_valid[0]
);
    import dcr_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_ONE = CH_W'(1);

    logic [15:0]        base_reg      [NUM_CHANNELS];
    logic [15:0]        base_next     [NUM_CHANNELS];
    logic [COUNT_W-1:0] reload_reg    [NUM_CHANNELS];
    logic [COUNT_W-1:0] reload_next   [NUM_CHANNELS];
    logic [COUNT_W-1:0] xfer_reg      [NUM_CHANNELS];
    logic [COUNT_W-1:0] xfer_next     [NUM_CHANNELS];
    logic [7:0]         page_reg      [NUM_CHANNELS];
    logic [7:0]         page_next     [NUM_CHANNELS];
    logic               mask_reg      [NUM_CHANNELS];
    logic               mask_next     [NUM_CHANNELS];
    logic               dir_reg       [NUM_CHANNELS];
    logic               dir_next      [NUM_CHANNELS];
    logic               auto_reg      [NUM_CHANNELS];
    logic               auto_next     [NUM_CHANNELS];
    logic               ff_reg;
    logic               ff_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         rd_data_reg;
    logic [7:0]         rd_data_next;
    logic [23:0]        addr_reg;
    logic [23:0]        addr_next;
    logic               fetch_reg;
    logic               fetch_next;

    logic [CH_W-1:0]    ch;
    logic [COUNT_W-1:0] tc;
    logic [COUNT_W-1:0] rl;
    logic [COUNT_W-1:0] cnt_val;
    logic [23:0]        base24;
    logic [23:0]        tc24;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {addr_reg, rd_data_reg};
    assign m_tuser  = fetch_reg;

    assign ch     = CH_W'(q_entry.chan);
    assign rl     = reload_reg[ch];
    assign tc     = (auto_reg[ch] && (xfer_reg[ch] > rl)) ? '0 : xfer_reg[ch];
    assign base24 = {page_reg[ch], base_reg[ch]};
    assign tc24   = 24'(tc);

    always_comb
    begin
        base_next      = base_reg;
        reload_next    = reload_reg;
        xfer_next      = xfer_reg;
        page_next      = page_reg;
        mask_next      = mask_reg;
        dir_next       = dir_reg;
        auto_next      = auto_reg;
        ff_next        = ff_reg;
        out_valid_next = out_valid_reg;
        rd_data_next   = rd_data_reg;
        addr_next      = addr_reg;
        fetch_next     = fetch_reg;
        cnt_val        = reload_reg[CH_ONE];

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            out_valid_next = 1'b1;
            rd_data_next   = '0;
            addr_next      = '0;
            fetch_next     = 1'b0;
            unique case (q_entry.op)
                OP_WR_ADDR:
                begin
                    if (ff_reg)
                    begin
                        base_next[CH_ONE][15:8] = q_entry.data;
                    end
                    else
                    begin
                        base_next[CH_ONE][7:0] = q_entry.data;
                    end
                    ff_next = !ff_reg;
                end
                OP_WR_COUNT:
                begin
                    if (ff_reg)
                    begin
                        cnt_val = {1'b0, q_entry.data, reload_reg[CH_ONE][7:0]};
                        if (cnt_val == '0)
                        begin
                            cnt_val = COUNT_FULL;
                        end
                        xfer_next[CH_ONE] = '0;
                    end
                    else
                    begin
                        cnt_val = {1'b0, reload_reg[CH_ONE][15:8], q_entry.data};
                    end
                    reload_next[CH_ONE] = cnt_val;
                    ff_next = !ff_reg;
                end
                OP_WR_MASK:
                begin
                    mask_next[ch] = q_entry.data[2];
                end
                OP_WR_MODE:
                begin
                    dir_next[ch]  = q_entry.data[5];
                    auto_next[ch] = q_entry.data[4];
                end
                OP_CLR_FF:
                begin
                    ff_next = 1'b0;
                end
                OP_WR_PAGE:
                begin
                    page_next[CH_ONE] = q_entry.data;
                end
                OP_RD_COUNT:
                begin
                    rd_data_next = ff_reg ? reload_reg[CH_ONE][15:8]
                                          : reload_reg[CH_ONE][7:0];
                    ff_next = !ff_reg;
                end
                OP_FETCH:
                begin
                    if (!mask_reg[ch] && !(tc > rl))
                    begin
                        fetch_next    = 1'b1;
                        addr_next     = dir_reg[ch] ? (base24 - tc24) : (base24 + tc24);
                        xfer_next[ch] = tc + 1'b1;
                    end
                end
                OP_NOP:
                begin
                    ff_next = ff_reg;
                end
                default:
                begin
                    ff_next = ff_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                base_reg[i]   <= '0;
                reload_reg[i] <= '0;
                xfer_reg[i]   <= '0;
                page_reg[i]   <= '0;
                mask_reg[i]   <= 1'b0;
                dir_reg[i]    <= 1'b0;
                auto_reg[i]   <= 1'b0;
            end
            ff_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            reload_reg    <= reload_next;
            xfer_reg      <= xfer_next;
            page_reg      <= page_next;
            mask_reg      <= mask_next;
            dir_reg       <= dir_next;
            auto_reg      <= auto_next;
            ff_reg        <= ff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= rd_data_next;
        addr_reg    <= addr_next;
        fetch_reg   <= fetch_next;
    end

endmodule

// ===== hw/rtl/dma_controller_channel_regs.sv =====
// Top level of the DMA channel register block: front end, queue and back end.
//
// Usage: each slave-side transaction carries one bus operation (port write,
// port read or DMA byte fetch request, selected by s_tuser). Every accepted
// transaction yields exactly one master-side transaction with the read byte,
// the 24-bit fetch address and the fetch-issued flag in m_tuser.
// Flow: the transaction is written into the decode queue at the accepting
// edge and executed when the back end pops it from the queue, which loads
// the output register that drives m_tvalid.
// Throughput: one transaction per cycle unless m_tready stalls the output,
// set by the execute stage that reads and updates the channel registers.
// Reset: all channel registers, the byte flip-flop, the queue and the output
// valid flag are cleared at once (the output data is not reset); the block
// accepts input as soon as reset is released.
// Stall: while m_tready is low the output register holds its result, the
// two-entry queue fills, and s_tready drops once the queue is full.
module dma_controller_channel_regs #(
    parameter int NUM_CHANNELS = dcr_pkg::DEF_NUM_CHANNELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dcr_pkg::S_TDATA_W-1:0] s_tdata,  // port[7:0], write_data[15:8], dma_channel[17:16]
    input  logic [dcr_pkg::S_TUSER_W-1:0] s_tuser,  // func[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dcr_pkg::M_TDATA_W-1:0] m_tdata,  // read_data[7:0], mem_addr[31:8]
    output logic [dcr_pkg::M_TUSER_W-1:0] m_tuser   // fetch_valid[0]
);
    import dcr_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_valid;
    qentry_t q_in;
    qentry_t q_out;

    dcr_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    dcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .pop_entry  (q_out)
    );

    dcr_back #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_entry  (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_fetch_no_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[7:0] == 8'h00))
        else $error("fetch result carries read data");

    a_no_fetch_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:8] == 24'h000000))
        else $error("non-fetch result carries an address");

    a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("queued transaction did not reach the output register");
`endif

endmodule
